[sv/pkd_pkg.sv]
// Shared types, codes and key table for the packet byte descrambler.
package pkd_pkg;

    localparam int KEY_TABLE_PAIRS = 256;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_MIN_SIZE = 1'b0;
    localparam logic CFG_MAX_SIZE = 1'b1;

    localparam logic [7:0]  MIN_SIZE_RST = 8'd12;
    localparam logic [15:0] MAX_SIZE_RST = 16'd8192;

    // Header positions within a packet
    localparam logic [15:0] POS_SIZE_LO = 16'd0;
    localparam logic [15:0] POS_SIZE_HI = 16'd1;
    localparam logic [15:0] POS_KEY     = 16'd2;
    localparam logic [15:0] POS_CHECK   = 16'd3;

    // Body byte offset from packet start
    localparam logic [7:0] BODY_OFFSET = 8'd4;

    // Body descramble ops, selected by position mod 4
    localparam logic [1:0] OP_SUB_SHL1 = 2'd0;
    localparam logic [1:0] OP_ADD_SHR3 = 2'd1;
    localparam logic [1:0] OP_SUB_SHL2 = 2'd2;
    localparam logic [1:0] OP_ADD_SHR5 = 2'd3;

    typedef struct packed {
        logic [15:0] packet_size;
        logic [1:0]  status;
        logic        last;
        logic [7:0]  out_byte;
    } t_result;

    localparam logic [7:0] KEY_ROM [0:2*KEY_TABLE_PAIRS-1] = '{
        8'h84, 8'h87, 8'h37, 8'hd7, 8'hea, 8'h79, 8'h91, 8'h7d,
        8'h4b, 8'h4b, 8'h85, 8'h7d, 8'h87, 8'h81, 8'h91, 8'h7c,
        8'h0f, 8'h73, 8'h91, 8'h91, 8'h87, 8'h7d, 8'h0d, 8'h7d,
        8'h86, 8'h8f, 8'h73, 8'h0f, 8'he1, 8'hdd, 8'h85, 8'h7d,
        8'h05, 8'h7d, 8'h85, 8'h83, 8'h87, 8'h9c, 8'h85, 8'h33,
        8'h0d, 8'he2, 8'h87, 8'h19, 8'h0f, 8'h79, 8'h85, 8'h86,
        8'h37, 8'h7d, 8'hd7, 8'hdd, 8'he9, 8'h7d, 8'hd7, 8'h7d,
        8'h85, 8'h79, 8'h05, 8'h7d, 8'h0f, 8'he1, 8'h87, 8'h7e,
        8'h23, 8'h87, 8'hf5, 8'h79, 8'h5f, 8'he3, 8'h4b, 8'h83,
        8'ha3, 8'ha2, 8'hae, 8'h0e, 8'h14, 8'h7d, 8'hde, 8'h7e,
        8'h85, 8'h7a, 8'h85, 8'haf, 8'hcd, 8'h7d, 8'h87, 8'ha5,
        8'h87, 8'h7d, 8'he1, 8'h7d, 8'h88, 8'h7d, 8'h15, 8'h91,
        8'h23, 8'h7d, 8'h87, 8'h7c, 8'h0d, 8'h7a, 8'h85, 8'h87,
        8'h17, 8'h7c, 8'h85, 8'h7d, 8'hac, 8'h80, 8'hbb, 8'h79,
        8'h84, 8'h9b, 8'h5b, 8'ha5, 8'hd7, 8'h8f, 8'h05, 8'h0f,
        8'h85, 8'h7e, 8'h85, 8'h80, 8'h85, 8'h98, 8'hf5, 8'h9d,
        8'ha3, 8'h1a, 8'h0d, 8'h19, 8'h87, 8'h7c, 8'h85, 8'h7d,
        8'h84, 8'h7d, 8'h85, 8'h7e, 8'he7, 8'h97, 8'h0d, 8'h0f,
        8'h85, 8'h7b, 8'hea, 8'h7d, 8'had, 8'h80, 8'had, 8'h7d,
        8'hb7, 8'haf, 8'h0d, 8'h7d, 8'he9, 8'h3d, 8'h85, 8'h7d,
        8'h87, 8'hb7, 8'h23, 8'h7d, 8'he7, 8'hb7, 8'ha3, 8'h0c,
        8'h87, 8'h7e, 8'h85, 8'ha5, 8'h7d, 8'h76, 8'h35, 8'hb9,
        8'h0d, 8'h6f, 8'h23, 8'h7d, 8'h87, 8'h9b, 8'h85, 8'h0c,
        8'he1, 8'ha1, 8'h0d, 8'h7f, 8'h87, 8'h7d, 8'h84, 8'h7a,
        8'h84, 8'h7b, 8'he1, 8'h86, 8'he8, 8'h6f, 8'hd1, 8'h79,
        8'h85, 8'h19, 8'h53, 8'h95, 8'hc3, 8'h47, 8'h19, 8'h7d,
        8'he7, 8'h0c, 8'h37, 8'h7c, 8'h23, 8'h7d, 8'h85, 8'h7d,
        8'h4b, 8'h79, 8'h21, 8'ha5, 8'h87, 8'h7d, 8'h19, 8'h7d,
        8'h0d, 8'h7d, 8'h15, 8'h91, 8'h23, 8'h7d, 8'h87, 8'h7c,
        8'h85, 8'h7a, 8'h85, 8'haf, 8'hcd, 8'h7d, 8'h87, 8'h7d,
        8'he9, 8'h3d, 8'h85, 8'h7d, 8'h15, 8'h79, 8'h85, 8'h7d,
        8'hc1, 8'h7b, 8'hea, 8'h7d, 8'hb7, 8'h7d, 8'h85, 8'h7d,
        8'h85, 8'h7d, 8'h0d, 8'h7d, 8'he9, 8'h73, 8'h85, 8'h79,
        8'h05, 8'h7d, 8'hd7, 8'h7d, 8'h85, 8'he1, 8'hb9, 8'he1,
        8'h0f, 8'h65, 8'h85, 8'h86, 8'h2d, 8'h7d, 8'hd7, 8'hdd,
        8'ha3, 8'h8e, 8'he6, 8'h7d, 8'hde, 8'h7e, 8'hae, 8'h0e,
        8'h0f, 8'he1, 8'h89, 8'h7e, 8'h23, 8'h7d, 8'hf5, 8'h79,
        8'h23, 8'he1, 8'h4b, 8'h83, 8'h0c, 8'h0f, 8'h85, 8'h7b,
        8'h85, 8'h7e, 8'h8f, 8'h80, 8'h85, 8'h98, 8'hf5, 8'h7a,
        8'h85, 8'h1a, 8'h0d, 8'he1, 8'h0f, 8'h7c, 8'h89, 8'h0c,
        8'h85, 8'h0b, 8'h23, 8'h69, 8'h87, 8'h7b, 8'h23, 8'h0c,
        8'h1f, 8'hb7, 8'h21, 8'h7a, 8'h88, 8'h7e, 8'h8f, 8'ha5,
        8'h7d, 8'h80, 8'hb7, 8'hb9, 8'h18, 8'hbf, 8'h4b, 8'h19,
        8'h85, 8'ha5, 8'h91, 8'h80, 8'h87, 8'h81, 8'h87, 8'h7c,
        8'h0f, 8'h73, 8'h91, 8'h91, 8'h84, 8'h87, 8'h37, 8'hd7,
        8'h86, 8'h79, 8'he1, 8'hdd, 8'h85, 8'h7a, 8'h73, 8'h9b,
        8'h05, 8'h7d, 8'h0d, 8'h83, 8'h87, 8'h9c, 8'h85, 8'h33,
        8'h87, 8'h7d, 8'h85, 8'h0f, 8'h87, 8'h7d, 8'h0d, 8'h7d,
        8'hf6, 8'h7e, 8'h87, 8'h7d, 8'h88, 8'h19, 8'h89, 8'hf5,
        8'hd1, 8'hdd, 8'h85, 8'h7d, 8'h8b, 8'hc3, 8'hea, 8'h7a,
        8'hd7, 8'hb0, 8'h0d, 8'h7d, 8'h87, 8'ha5, 8'h87, 8'h7c,
        8'h73, 8'h7e, 8'h7d, 8'h86, 8'h87, 8'h23, 8'h85, 8'h10,
        8'hd7, 8'hdf, 8'hed, 8'ha5, 8'he1, 8'h7a, 8'h85, 8'h23,
        8'hea, 8'h7e, 8'h85, 8'h98, 8'had, 8'h79, 8'h86, 8'h7d,
        8'h85, 8'h7d, 8'hd7, 8'h7d, 8'he1, 8'h7a, 8'hf5, 8'h7d,
        8'h85, 8'hb0, 8'h2b, 8'h37, 8'he1, 8'h7a, 8'h87, 8'h79,
        8'h84, 8'h7d, 8'h73, 8'h73, 8'h87, 8'h7d, 8'h23, 8'h7d,
        8'he9, 8'h7d, 8'h85, 8'h7e, 8'h02, 8'h7d, 8'hdd, 8'h2d,
        8'h87, 8'h79, 8'he7, 8'h79, 8'had, 8'h7c, 8'h23, 8'hda,
        8'h87, 8'h0d, 8'h0d, 8'h7b, 8'he7, 8'h79, 8'h9b, 8'h7d,
        8'hd7, 8'h8f, 8'h05, 8'h7d, 8'h0d, 8'h34, 8'h8f, 8'h7d,
        8'had, 8'h87, 8'he9, 8'h7c, 8'h85, 8'h80, 8'h85, 8'h79,
        8'h8a, 8'hc3, 8'he7, 8'ha5, 8'he8, 8'h6b, 8'h0d, 8'h74,
        8'h10, 8'h73, 8'h33, 8'h17, 8'h0d, 8'h37, 8'h21, 8'h19
    };

    // Start position for a key index (even entry of the pair)
    function automatic logic [7:0] key_start_of(input logic [7:0] key_idx);
        return KEY_ROM[{key_idx, 1'b0}];
    endfunction

    // Scramble value of a pair (odd entry of the pair)
    function automatic logic [7:0] key_value_of(input logic [7:0] pair);
        return KEY_ROM[{pair, 1'b1}];
    endfunction

endpackage

[sv/pkd_descramble.sv]
// Body byte descramble: one key table lookup and one add or subtract.
module pkd_descramble
    import pkd_pkg::*;
(
    input  logic [7:0] i_key_start,
    input  logic [7:0] i_pos,      // low byte of position in packet
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] w_pair;
    logic [7:0] w_key;

    assign w_pair = i_key_start + i_pos - BODY_OFFSET;
    assign w_key  = key_value_of(w_pair);

    // Op follows position mod 4
    always_comb begin
        case (i_pos[1:0])
            OP_SUB_SHL1: o_byte = i_byte - {w_key[6:0], 1'b0};
            OP_ADD_SHR3: o_byte = i_byte + {3'b000, w_key[7:3]};
            OP_SUB_SHL2: o_byte = i_byte - {w_key[5:0], 2'b00};
            OP_ADD_SHR5: o_byte = i_byte + {5'b00000, w_key[7:5]};
            default:     o_byte = i_byte;
        endcase
    end

endmodule

[sv/pkd_parser.sv]
// Packet parser: header tracking, size check, running sums and result build.
module pkd_parser
    import pkd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,      // process i_byte this cycle
    input  logic [7:0]  i_byte,
    input  logic [7:0]  i_min_size,
    input  logic [15:0] i_max_size,
    output t_result     o_result
);

    logic [15:0] r_byte_index, n_byte_index;
    logic [15:0] r_size_value, n_size_value;
    logic [7:0]  r_key_start,  n_key_start;
    logic [7:0]  r_check_byte, n_check_byte;
    logic [7:0]  r_raw_sum,    n_raw_sum;
    logic [7:0]  r_plain_sum,  n_plain_sum;

    logic [7:0]  w_plain;
    logic [15:0] w_size_full;
    logic [16:0] w_next_pos;

    pkd_descramble u_descramble (
        .i_key_start (r_key_start),
        .i_pos       (r_byte_index[7:0]),
        .i_byte      (i_byte),
        .o_byte      (w_plain)
    );

    assign w_size_full = {i_byte, r_size_value[7:0]};
    assign w_next_pos  = {1'b0, r_byte_index} + 17'd1;

    // Next state and result for the byte at hand
    always_comb begin
        n_byte_index = r_byte_index;
        n_size_value = r_size_value;
        n_key_start  = r_key_start;
        n_check_byte = r_check_byte;
        n_raw_sum    = r_raw_sum;
        n_plain_sum  = r_plain_sum;
        o_result.out_byte = i_byte;
        o_result.last     = 1'b0;
        o_result.status   = STATUS_OK;

        if (r_byte_index == POS_SIZE_LO) begin
            n_size_value = {8'h00, i_byte};
            n_raw_sum    = 8'h00;
            n_plain_sum  = 8'h00;
            n_byte_index = POS_SIZE_HI;
        end else if (r_byte_index == POS_SIZE_HI) begin
            n_size_value = w_size_full;
            if (w_size_full < {8'h00, i_min_size} || w_size_full >= i_max_size) begin
                o_result.last   = 1'b1;
                o_result.status = STATUS_BAD_SIZE;
                n_byte_index    = POS_SIZE_LO;
            end else begin
                n_byte_index = POS_KEY;
            end
        end else if (r_byte_index == POS_KEY) begin
            n_key_start  = key_start_of(i_byte);
            n_byte_index = POS_CHECK;
        end else begin
            if (r_byte_index == POS_CHECK) begin
                n_check_byte = i_byte;
            end else begin
                o_result.out_byte = w_plain;
                n_raw_sum   = r_raw_sum + i_byte;
                n_plain_sum = r_plain_sum + w_plain;
            end
            // End of packet: compare sum difference with checksum
            if (w_next_pos >= {1'b0, r_size_value}) begin
                o_result.last = 1'b1;
                if ((n_raw_sum - n_plain_sum) != n_check_byte) begin
                    o_result.status = STATUS_CHECKSUM;
                end
                n_byte_index = POS_SIZE_LO;
            end else begin
                n_byte_index = w_next_pos[15:0];
            end
        end

        o_result.packet_size = (r_byte_index == POS_SIZE_LO) ? 16'h0000 : n_size_value;
    end

    // Packet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_size_value <= '0;
            r_key_start  <= '0;
            r_check_byte <= '0;
            r_raw_sum    <= '0;
            r_plain_sum  <= '0;
        end else if (i_fire) begin
            r_byte_index <= n_byte_index;
            r_size_value <= n_size_value;
            r_key_start  <= n_key_start;
            r_check_byte <= n_check_byte;
            r_raw_sum    <= n_raw_sum;
            r_plain_sum  <= n_plain_sum;
        end
    end

endmodule

[sv/packet_byte_descrambler.sv]
// Each input byte is captured in the input register, and its result then in the result register.
// Throughput: one byte per cycle; the byte in the input register is processed whenever the
// result register is empty or being taken, so both sides can stream back to back.
// Each byte costs one key table lookup and one 8-bit add or subtract in the path between the two registers.
// Reset (i_rst_n low, synchronous) empties both registers, clears packet state and loads the
// size limits with 12 and 8192.
module packet_byte_descrambler
    import pkd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] packet_size
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_out_vld;
    t_result     r_out;
    logic [7:0]  r_min_size;
    logic [15:0] r_max_size;

    logic        w_proc;
    t_result     w_result;

    assign w_proc        = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_proc;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_size <= MIN_SIZE_RST;
            r_max_size <= MAX_SIZE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_MIN_SIZE) begin
                r_min_size <= i_cfg_wdata[7:0];
            end else if (i_cfg_addr == CFG_MAX_SIZE) begin
                r_max_size <= i_cfg_wdata;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (w_proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    pkd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_proc),
        .i_byte     (r_in_byte),
        .i_min_size (r_min_size),
        .i_max_size (r_max_size),
        .o_result   (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_proc) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.packet_size, r_out.out_byte};
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tuser  = r_out.status;

endmodule

[sv/pkd_checker.sv]
// Port-level checker for the packet byte descrambler, with its bind.
module pkd_checker
    import pkd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    // Any error status closes the packet
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> m_axis_tlast)
        else $error("error status without tlast");

    // Input side only stalls while a result is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with free result register");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind packet_byte_descrambler pkd_checker u_pkd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
